// ===== hw/rtl/anf_pkg.sv =====
// Types, constants and microcode encodings shared by the adaptive notch filter.
package anf_pkg;

    // Field widths of the channel payloads, the configuration register and the internal datapath.
    localparam int SAMPLE_W    = 16;
    localparam int ERROR_W     = 32;
    localparam int COEF_W      = 15;
    localparam int STEP_SIZE_W = 15;
    localparam int RADIUS_W    = 16;
    localparam int WORD_W      = 32;
    localparam int PROD_W      = 64;
    localparam int STEP_W      = 4;

    typedef logic signed [SAMPLE_W-1:0]    t_sample;
    typedef logic signed [ERROR_W-1:0]     t_error;
    typedef logic signed [COEF_W-1:0]      t_coef;
    typedef logic        [STEP_SIZE_W-1:0] t_step_size;
    typedef logic signed [RADIUS_W-1:0]    t_radius;
    typedef logic signed [WORD_W-1:0]      t_word;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic        [STEP_W-1:0]      t_step;

    // Q15 constants of the pole radius relaxation.
    localparam int DECAY_Q15     = 31129;
    localparam int RHO_FINAL_Q15 = 26214;
    localparam int ONE_Q15       = 32768;
    localparam int RELAX_BIAS    = (ONE_Q15 - DECAY_Q15) * RHO_FINAL_Q15;

    // Coefficient saturation limits, Q14.
    localparam int COEF_MAX = (1 << 14) - 1;
    localparam int COEF_MIN = -(1 << 14);

    // Reset values of the architectural state.
    localparam t_radius    RHO_RESET       = 16'sh7333;
    localparam t_radius    RHO_SQ_RESET    = 16'sh0CCD;
    localparam t_step_size STEP_SIZE_RESET = 15'd1;

    // Multiplier operand A sources.
    typedef enum logic [2:0] {
        OPA_RHO,
        OPA_RHOSQ,
        OPA_COEF,
        OPA_PROD_LO,
        OPA_PROD_MID,
        OPA_D1
    } t_opa;

    // Multiplier operand B sources.
    typedef enum logic [2:0] {
        OPB_DECAY,
        OPB_RHO,
        OPB_D1,
        OPB_D2,
        OPB_ACC,
        OPB_STEP
    } t_opb;

    // Accumulator and state update operations.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_RHO,
        ACC_RHOSQ,
        ACC_LOAD,
        ACC_DELAY,
        ACC_ERROR,
        ACC_FINISH
    } t_acc_op;

    // Sequencing condition of a microcode word.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_JUMP_OUT
    } t_seq_cond;

    typedef struct packed {
        t_opa      opa;
        t_opb      opb;
        t_acc_op   acc_op;
        t_seq_cond cond;
        t_step     target;
    } t_uword;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        t_opa    opa;
        t_opb    opb;
        t_acc_op acc_op;
        logic    advance;
    } t_dp_ctrl;

endpackage

// ===== hw/rtl/anf_sample_if.sv =====
// Input channel carrying one Q15 sample per transaction.
interface anf_sample_if import anf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/anf_result_if.sv =====
// Output channel carrying the notch error and the coefficient per transaction.
interface anf_result_if import anf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_error error_out;
    t_coef  coefficient_out;

    modport source (output valid, output error_out, output coefficient_out, input ready);
    modport sink (input valid, input error_out, input coefficient_out, output ready);
endinterface

// ===== hw/rtl/anf_mul.sv =====
// Shared 32 by 32 signed multiplier with a registered product.
module anf_mul import anf_pkg::*; (
    input  logic  i_clk,
    input  t_word i_opa,
    input  t_word i_opb,
    output t_prod o_prod
);

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_opa * i_opb;
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/anf_seq.sv =====
// Microcode sequencer: step counter, program table and jump logic.
module anf_seq import anf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    output logic     o_in_ready,
    output t_dp_ctrl o_ctrl
);

    // Program addresses.
    localparam t_step S_IDLE   = 4'd0;
    localparam t_step S_RELAX  = 4'd1;
    localparam t_step S_RADIUS = 4'd2;
    localparam t_step S_SQUARE = 4'd3;
    localparam t_step S_RSQ    = 4'd4;
    localparam t_step S_FB1    = 4'd5;
    localparam t_step S_FB2    = 4'd6;
    localparam t_step S_STORE  = 4'd7;
    localparam t_step S_ERROR  = 4'd8;
    localparam t_step S_GRAD   = 4'd9;
    localparam t_step S_SCALE  = 4'd10;
    localparam t_step S_UPDATE = 4'd11;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_advance;

    // The product of each multiply lands in the product register, where the next step reads it.
    // The gradient step waits for a free output register; its operands do not
    // change while it waits, so the product seen by the next step stays valid.
    always_comb begin
        case (r_step)
            S_IDLE:   w_uword = '{OPA_RHO,      OPB_DECAY, ACC_NONE,   SEQ_WAIT_IN,  S_IDLE};
            S_RELAX:  w_uword = '{OPA_RHO,      OPB_DECAY, ACC_NONE,   SEQ_NEXT,     S_IDLE};
            S_RADIUS: w_uword = '{OPA_RHO,      OPB_RHO,   ACC_RHO,    SEQ_NEXT,     S_IDLE};
            S_SQUARE: w_uword = '{OPA_RHO,      OPB_RHO,   ACC_NONE,   SEQ_NEXT,     S_IDLE};
            S_RSQ:    w_uword = '{OPA_COEF,     OPB_RHO,   ACC_RHOSQ,  SEQ_NEXT,     S_IDLE};
            S_FB1:    w_uword = '{OPA_PROD_LO,  OPB_D1,    ACC_NONE,   SEQ_NEXT,     S_IDLE};
            S_FB2:    w_uword = '{OPA_RHOSQ,    OPB_D2,    ACC_LOAD,   SEQ_NEXT,     S_IDLE};
            S_STORE:  w_uword = '{OPA_COEF,     OPB_D1,    ACC_DELAY,  SEQ_NEXT,     S_IDLE};
            S_ERROR:  w_uword = '{OPA_RHO,      OPB_RHO,   ACC_ERROR,  SEQ_NEXT,     S_IDLE};
            S_GRAD:   w_uword = '{OPA_D1,       OPB_ACC,   ACC_NONE,   SEQ_WAIT_OUT, S_IDLE};
            S_SCALE:  w_uword = '{OPA_PROD_MID, OPB_STEP,  ACC_NONE,   SEQ_NEXT,     S_IDLE};
            S_UPDATE: w_uword = '{OPA_RHO,      OPB_RHO,   ACC_FINISH, SEQ_JUMP_OUT, S_IDLE};
            default:  w_uword = '{OPA_RHO,      OPB_RHO,   ACC_NONE,   SEQ_JUMP_OUT, S_IDLE};
        endcase
    end

    always_comb begin
        case (w_uword.cond)
            SEQ_NEXT:     w_advance = 1'b1;
            SEQ_WAIT_IN:  w_advance = i_in_valid;
            SEQ_WAIT_OUT: w_advance = i_out_free;
            SEQ_JUMP_OUT: w_advance = i_out_free;
            default:      w_advance = 1'b0;
        endcase
        n_step = r_step;
        if (w_advance) begin
            if (w_uword.cond == SEQ_JUMP_OUT) begin
                n_step = w_uword.target;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready     = (w_uword.cond == SEQ_WAIT_IN);
    assign o_ctrl.opa     = w_uword.opa;
    assign o_ctrl.opb     = w_uword.opb;
    assign o_ctrl.acc_op  = w_uword.acc_op;
    assign o_ctrl.advance = w_advance;

endmodule

// ===== hw/rtl/anf_datapath.sv =====
// Datapath: filter state, operand selection, accumulator and coefficient update.
module anf_datapath import anf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_ctrl   i_ctrl,
    input  logic       i_in_accept,
    input  t_sample    i_sample,
    input  logic       i_cfg_wr_en,
    input  t_step_size i_cfg_wr_data,
    output t_error     o_error,
    output t_coef      o_coefficient
);

    // Architectural state. The circular delay line is kept as two taps:
    // r_d1 is the older entry, read with the coefficient, r_d2 the newest one.
    t_radius    r_rho;
    t_radius    r_rho_sq;
    t_coef      r_coef;
    t_word      r_d1;
    t_word      r_d2;
    t_step_size r_step_size;

    // Working registers.
    t_sample r_y;
    t_word   r_acc;
    t_word   r_dnew;
    t_error  r_err;

    t_word            w_opa;
    t_word            w_opb;
    t_prod            w_prod;
    t_word            w_hi;
    t_word            w_relax;
    t_word            w_delay;
    t_word            w_error;
    logic signed [32:0] w_coef_sum;
    t_coef            w_coef_new;

    anf_mul u_mul (
        .i_clk  (i_clk),
        .i_opa  (w_opa),
        .i_opb  (w_opb),
        .o_prod (w_prod)
    );

    always_comb begin
        case (i_ctrl.opa)
            OPA_RHO:      w_opa = WORD_W'(r_rho);
            OPA_RHOSQ:    w_opa = WORD_W'(r_rho_sq);
            OPA_COEF:     w_opa = WORD_W'(r_coef);
            OPA_PROD_LO:  w_opa = w_prod[31:0];
            OPA_PROD_MID: w_opa = w_prod[45:14];
            OPA_D1:       w_opa = r_d1;
            default:      w_opa = '0;
        endcase
        case (i_ctrl.opb)
            OPB_DECAY: w_opb = WORD_W'(DECAY_Q15);
            OPB_RHO:   w_opb = WORD_W'(r_rho);
            OPB_D1:    w_opb = r_d1;
            OPB_D2:    w_opb = r_d2;
            OPB_ACC:   w_opb = r_acc;
            OPB_STEP:  w_opb = {{(WORD_W-STEP_SIZE_W){1'b0}}, r_step_size};
            default:   w_opb = '0;
        endcase
    end

    // Only the low 32 bits of each shifted term reach the wrapped results,
    // so the product is sliced instead of carried at full width.
    always_comb begin
        w_hi       = w_prod[46:15];
        w_relax    = w_prod[31:0] + WORD_W'(RELAX_BIAS);
        w_delay    = r_acc - w_hi + WORD_W'(r_y);
        w_error    = {r_acc[28:0], 3'b000} - w_hi + {r_d2[28:0], 3'b000};
        w_coef_sum = 33'(r_coef) + {w_prod[31], w_prod[31:0]};
        if (w_coef_sum > 33'(COEF_MAX)) begin
            w_coef_new = COEF_W'(COEF_MAX);
        end else if (w_coef_sum < 33'(COEF_MIN)) begin
            w_coef_new = COEF_W'(COEF_MIN);
        end else begin
            w_coef_new = w_coef_sum[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho       <= RHO_RESET;
            r_rho_sq    <= RHO_SQ_RESET;
            r_coef      <= '0;
            r_d1        <= '0;
            r_d2        <= '0;
            r_step_size <= STEP_SIZE_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_step_size <= i_cfg_wr_data;
            end
            if (i_ctrl.advance) begin
                case (i_ctrl.acc_op)
                    ACC_RHO:    r_rho    <= w_relax[30:15];
                    ACC_RHOSQ:  r_rho_sq <= w_prod[30:15];
                    ACC_FINISH: begin
                        r_coef <= w_coef_new;
                        r_d1   <= r_d2;
                        r_d2   <= r_dnew;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_y <= i_sample;
        end
        if (i_ctrl.advance) begin
            case (i_ctrl.acc_op)
                ACC_LOAD:  r_acc <= w_hi;
                ACC_DELAY: begin
                    r_acc  <= w_delay;
                    r_dnew <= w_delay;
                end
                ACC_ERROR:  r_acc <= w_error;
                ACC_FINISH: r_err <= r_acc;
                default: ;
            endcase
        end
    end

    assign o_error       = r_err;
    assign o_coefficient = r_coef;

endmodule

// ===== hw/rtl/adaptive_notch_filter_q15.sv =====
// Top level of the LMS adaptive second-order notch filter on Q15 samples.
//
//   channel      direction  payload                              handshake
//   i_sample     in         sample (16b signed, Q15)             valid / ready
//   o_result     out        error_out (32b), coefficient_out     valid / ready
//   i_cfg_wr_*   in         step_size (15b unsigned)             write enable only
//
// Each item runs through one wait step and eleven microcode steps that share
// a single registered 32x32 multiplier; the next sample is accepted only
// after the last of them, back in the wait step.
// The result sits in an output register, so the next sample is processed while
// an earlier transaction waits to be taken; the gradient step stalls only if the
// previous result is still held. Reset is synchronous and active low and has
// no clearing pass; step_size returns to 1 and may be written whenever idle.
module adaptive_notch_filter_q15 import anf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    anf_sample_if.sink        i_sample,
    anf_result_if.source      o_result,
    input  logic              i_cfg_wr_en,
    input  t_step_size        i_cfg_wr_data
);

    t_dp_ctrl w_ctrl;
    logic     w_in_ready;
    logic     w_in_accept;
    logic     w_out_free;
    logic     w_finish;
    logic     r_out_valid;
    t_error   w_error;
    t_coef    w_coef;

    // A sample transaction completes when the sequencer sits in its wait step
    // and the source offers valid data. Nothing is taken while reset is held.
    assign i_sample.ready = w_in_ready & i_rst_n;
    assign w_in_accept    = i_sample.valid & i_sample.ready;

    // The output register can take a new result when it is empty or when its
    // current transaction completes at this edge.
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_finish   = w_ctrl.advance && (w_ctrl.acc_op == ACC_FINISH);

    anf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_out_free (w_out_free),
        .o_in_ready (w_in_ready),
        .o_ctrl     (w_ctrl)
    );

    anf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_in_accept   (w_in_accept),
        .i_sample      (i_sample.sample),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_error       (w_error),
        .o_coefficient (w_coef)
    );

    // Result valid is set by the final microcode step and cleared when the
    // sink takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The coefficient register only changes in the final step, which follows
    // the wait for a free output register, so it can drive the port directly.
    assign o_result.valid           = r_out_valid;
    assign o_result.error_out       = w_error;
    assign o_result.coefficient_out = w_coef;

    // After a sample is taken the sequencer is busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> !i_sample.ready)
        else $error("sample ready stayed high after an accepted transaction");

    // A new result appears only as the product of the final microcode step.
    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_finish))
        else $error("result valid rose without a coefficient update");

    // The final step never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (!r_out_valid || o_result.ready))
        else $error("pending result overwritten");

    // While waiting for a sample the datapath state is left alone.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.ready |-> (w_ctrl.acc_op == ACC_NONE))
        else $error("datapath update issued during the wait step");

endmodule
